@@ sv/bbef_pkg.sv @@
// Shared constants for the box blur / edge map filter.
// Register index codes, reset values, pixel layout and filter constants.
// No dependencies.
package bbef_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_MAX_RADIUS = 8;

    localparam int CFG_DIM_W  = 9;
    localparam int CFG_RAD_W  = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLUR_RADIUS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE  = 2'd3;

    localparam logic [CFG_DIM_W-1:0] RST_DIM    = 9'd256;
    localparam logic [CFG_RAD_W-1:0] RST_RADIUS = 4'd1;
    localparam logic                 RST_MODE   = 1'b0;

    localparam logic MODE_BLUR = 1'b0;
    localparam logic MODE_EDGE = 1'b1;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_REQUEST = 1'b1;

    localparam int CHAN_W   = 8;
    localparam int NUM_CHAN = 3;
    localparam int PIX_W    = CHAN_W * NUM_CHAN;

    localparam int                EDGE_RADIUS = 2;
    localparam logic [CHAN_W-1:0] WHITE       = 8'hFF;

endpackage

@@ sv/box_blur_edge_filter.sv @@
// Box blur / edge map filter: frame store, window scan and bit-serial dividers.
// Depends on bbef_pkg.
//
// A load (tuser = 0) writes the next raster pixel into the frame store in the load state
// and the block is ready again after that state. A request (tuser = 1) returns one filtered
// pixel in raster order: the row/column split of the position (AW, the store address width,
// 16 bits) and the three mean divisions (SW, the channel sum width, 17 bits) run one bit per
// cycle, and the window of up to (2*MAX_RADIUS+1)^2 pixels (289 at the defaults), clipped
// at the borders, is read through the single store read port at one pixel per cycle. A
// finished result sits in the output register, so the next request is taken while it waits.
// Store entries are not cleared at reset; request only pixels that were loaded.
module box_blur_edge_filter
    import bbef_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [PIX_W-1:0]      s_axis_tdata,   // red_in[7:0], green_in[15:8], blue_in[23:16]
    input  logic                  s_axis_tuser,   // cmd
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [PIX_W-1:0]      m_axis_tdata,   // red_out[7:0], green_out[15:8], blue_out[23:16]
    output logic                  m_axis_tlast,   // frame_last
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TW    = $clog2(DEPTH + 1);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int WIN_R = (MAX_RADIUS > EDGE_RADIUS) ? MAX_RADIUS : EDGE_RADIUS;
    localparam int RW    = $clog2(WIN_R + 1);
    localparam int WIN_N = (2 * WIN_R + 1) * (2 * WIN_R + 1);
    localparam int NW    = $clog2(WIN_N + 1);
    localparam int SW    = CHAN_W + NW;
    localparam int IW    = (AW > SW) ? AW : SW;
    localparam int CNTW  = $clog2(IW + 1);
    localparam int CWW   = (WW > CFG_DIM_W) ? WW : CFG_DIM_W;
    localparam int CWH   = (HW > CFG_DIM_W) ? HW : CFG_DIM_W;
    localparam int CWR   = (RW > CFG_RAD_W) ? RW : CFG_RAD_W;
    localparam int DW0   = (WW > HW) ? WW : HW;
    localparam int DW    = ((DW0 > RW) ? DW0 : RW) + 1;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_LOAD   = 4'd1;
    localparam logic [3:0] S_REQ    = 4'd2;
    localparam logic [3:0] S_DIVP   = 4'd3;
    localparam logic [3:0] S_BOUNDS = 4'd4;
    localparam logic [3:0] S_BASE   = 4'd5;
    localparam logic [3:0] S_SCAN   = 4'd6;
    localparam logic [3:0] S_DRAIN  = 4'd7;
    localparam logic [3:0] S_DIVM   = 4'd8;
    localparam logic [3:0] S_OUT    = 4'd9;

    // configuration
    logic [CFG_DIM_W-1:0] r_cfg_width, r_cfg_height;
    logic [CFG_RAD_W-1:0] r_cfg_radius;
    logic                 r_cfg_mode;

    logic [WW-1:0] eff_w;
    logic [HW-1:0] eff_h;
    logic [RW-1:0] eff_rad;
    logic [CWW-1:0] w_raw;
    logic [CWH-1:0] h_raw;
    logic [CWR-1:0] rad_raw;
    logic [WW+HW-1:0] total_prod;
    logic [TW-1:0] r_total;

    // control and position state
    logic [3:0]       r_state, n_state;
    logic [AW-1:0]    r_ld_pos, r_out_pos, r_pos;
    logic [PIX_W-1:0] r_pix;
    logic             r_cmd;
    logic [CNTW-1:0]  r_cnt;

    // row/column split
    logic [AW-1:0] r_dnum;
    logic [WW-1:0] r_drem;
    logic [WW:0]   dp_sh, dp_sub;
    logic [AW:0]   dp_num_sh;
    logic          dp_ge;

    // window
    logic [HW-1:0] r_y, r_y1;
    logic [WW-1:0] r_x, r_x0, r_x1;
    logic [AW-1:0] r_base;
    logic          r_pend;
    logic [NW-1:0] r_npix;
    logic [SW-1:0] r_sum [NUM_CHAN];
    logic [NW-1:0] r_mrem [NUM_CHAN];
    logic [PIX_W-1:0] r_center;

    logic [DW-1:0] b_row, b_col, b_rad, b_hm1, b_wm1, b_ysum, b_xsum, b_y0, b_x0, b_y1, b_x1;
    logic [HW+WW-1:0] base_prod;
    logic [TW-1:0] ld_norm, out_norm, ld_inc, pos_inc;
    logic          pos_last;

    logic [NW:0]   md_sh  [NUM_CHAN];
    logic [NW:0]   md_sub [NUM_CHAN];
    logic          md_ge  [NUM_CHAN];
    logic [CHAN_W-1:0] mean [NUM_CHAN];
    logic [CHAN_W-1:0] ctr  [NUM_CHAN];
    logic [CHAN_W-1:0] diff [NUM_CHAN];
    logic [PIX_W-1:0]  res_pix;

    // frame store
    logic [PIX_W-1:0] r_mem [DEPTH];
    logic [PIX_W-1:0] r_rd_data;
    logic [AW-1:0]    rd_addr;

    logic r_out_valid, r_out_last;
    logic [PIX_W-1:0] r_out_data;
    logic out_free;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;
    assign out_free      = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= RST_DIM;
            r_cfg_height <= RST_DIM;
            r_cfg_radius <= RST_RADIUS;
            r_cfg_mode   <= RST_MODE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_IMAGE_WIDTH:  r_cfg_width  <= i_cfg_data;
                REG_IMAGE_HEIGHT: r_cfg_height <= i_cfg_data;
                REG_BLUR_RADIUS:  r_cfg_radius <= i_cfg_data[CFG_RAD_W-1:0];
                REG_FILTER_MODE:  r_cfg_mode   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // effective sizes: zero width or height reads as one, oversize saturates, edge mode uses the edge radius
    always_comb begin
        w_raw   = CWW'(r_cfg_width);
        h_raw   = CWH'(r_cfg_height);
        rad_raw = CWR'(r_cfg_radius);
        if (r_cfg_width == '0)
            eff_w = WW'(1);
        else if (w_raw > CWW'(MAX_WIDTH))
            eff_w = WW'(MAX_WIDTH);
        else
            eff_w = WW'(w_raw);
        if (r_cfg_height == '0)
            eff_h = HW'(1);
        else if (h_raw > CWH'(MAX_HEIGHT))
            eff_h = HW'(MAX_HEIGHT);
        else
            eff_h = HW'(h_raw);
        if (r_cfg_mode == MODE_EDGE)
            eff_rad = RW'(EDGE_RADIUS);
        else if (rad_raw > CWR'(MAX_RADIUS))
            eff_rad = RW'(MAX_RADIUS);
        else
            eff_rad = RW'(rad_raw);
        total_prod = {{HW{1'b0}}, eff_w} * {{WW{1'b0}}, eff_h};
    end

    // pixel count is a registered copy of the config product; items use it only after acceptance
    always_ff @(posedge i_clk) begin
        r_total <= total_prod[TW-1:0];
    end

    always_comb begin
        ld_norm  = (TW'(r_ld_pos) >= r_total) ? '0 : TW'(r_ld_pos);
        out_norm = (TW'(r_out_pos) >= r_total) ? '0 : TW'(r_out_pos);
        ld_inc   = ld_norm + TW'(1);
        pos_inc  = TW'(r_pos) + TW'(1);
        pos_last = (pos_inc >= r_total);

        dp_sh     = {r_drem, r_dnum[AW-1]};
        dp_ge     = (dp_sh >= {1'b0, eff_w});
        dp_sub    = dp_sh - {1'b0, eff_w};
        dp_num_sh = {r_dnum, dp_ge};

        b_row  = DW'(r_dnum);
        b_col  = DW'(r_drem);
        b_rad  = DW'(eff_rad);
        b_hm1  = DW'(eff_h) - DW'(1);
        b_wm1  = DW'(eff_w) - DW'(1);
        b_ysum = b_row + b_rad;
        b_xsum = b_col + b_rad;
        b_y0   = (b_row > b_rad) ? b_row - b_rad : '0;
        b_x0   = (b_col > b_rad) ? b_col - b_rad : '0;
        b_y1   = (b_ysum < b_hm1) ? b_ysum : b_hm1;
        b_x1   = (b_xsum < b_wm1) ? b_xsum : b_wm1;

        base_prod = {{WW{1'b0}}, r_y} * {{HW{1'b0}}, eff_w};

        for (int i = 0; i < NUM_CHAN; i++) begin
            md_sh[i]  = {r_mrem[i], r_sum[i][SW-1]};
            md_ge[i]  = (md_sh[i] >= {1'b0, r_npix});
            md_sub[i] = md_sh[i] - {1'b0, r_npix};
            mean[i]   = r_sum[i][CHAN_W-1:0];
            ctr[i]    = r_center[CHAN_W*i +: CHAN_W];
            diff[i]   = (ctr[i] > mean[i]) ? ctr[i] - mean[i] : mean[i] - ctr[i];
            res_pix[CHAN_W*i +: CHAN_W] = (r_cfg_mode == MODE_EDGE) ? WHITE - diff[i] : mean[i];
        end

        rd_addr = (r_state == S_BOUNDS) ? r_pos : r_base + AW'(r_x);
    end

    // frame store: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (r_state == S_LOAD)
            r_mem[ld_norm[AW-1:0]] <= r_pix;
        r_rd_data <= r_mem[rd_addr];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid)
                    n_state = (s_axis_tuser == CMD_LOAD) ? S_LOAD : S_REQ;
            end
            S_LOAD:   n_state = S_IDLE;
            S_REQ:    n_state = S_DIVP;
            S_DIVP: begin
                if (r_cnt == CNTW'(1))
                    n_state = S_BOUNDS;
            end
            S_BOUNDS: n_state = S_BASE;
            S_BASE:   n_state = S_SCAN;
            S_SCAN: begin
                if (r_x == r_x1 && r_y == r_y1)
                    n_state = S_DRAIN;
            end
            S_DRAIN:  n_state = S_DIVM;
            S_DIVM: begin
                if (r_cnt == CNTW'(1))
                    n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free)
                    n_state = S_IDLE;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // once outside the frame, the load position folds back to zero on a request and the output position on a load
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ld_pos    <= '0;
            r_out_pos   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_LOAD) begin
                r_ld_pos  <= (ld_inc >= r_total) ? '0 : ld_inc[AW-1:0];
                r_out_pos <= out_norm[AW-1:0];
            end
            if (r_state == S_REQ)
                r_ld_pos <= ld_norm[AW-1:0];
            if (r_state == S_OUT && out_free)
                r_out_pos <= pos_last ? '0 : pos_inc[AW-1:0];
            if (r_state == S_OUT && out_free)
                r_out_valid <= 1'b1;
            else if (m_axis_tready)
                r_out_valid <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_pix <= s_axis_tdata;
                r_cmd <= s_axis_tuser;
            end
            S_REQ: begin
                r_pos  <= out_norm[AW-1:0];
                r_dnum <= out_norm[AW-1:0];
                r_drem <= '0;
                r_cnt  <= CNTW'(AW);
            end
            S_DIVP: begin
                r_dnum <= dp_num_sh[AW-1:0];
                r_drem <= dp_ge ? dp_sub[WW-1:0] : dp_sh[WW-1:0];
                r_cnt  <= r_cnt - CNTW'(1);
            end
            S_BOUNDS: begin
                r_y  <= HW'(b_y0);
                r_y1 <= HW'(b_y1);
                r_x0 <= WW'(b_x0);
                r_x  <= WW'(b_x0);
                r_x1 <= WW'(b_x1);
            end
            S_BASE: begin
                r_base   <= base_prod[AW-1:0];
                r_center <= r_rd_data;
                r_pend   <= 1'b0;
                r_npix   <= '0;
                for (int i = 0; i < NUM_CHAN; i++)
                    r_sum[i] <= '0;
            end
            S_SCAN, S_DRAIN: begin
                if (r_pend) begin
                    r_npix <= r_npix + NW'(1);
                    for (int i = 0; i < NUM_CHAN; i++)
                        r_sum[i] <= r_sum[i] + SW'(r_rd_data[CHAN_W*i +: CHAN_W]);
                end
                if (r_state == S_SCAN) begin
                    r_pend <= 1'b1;
                    if (r_x == r_x1) begin
                        r_x <= r_x0;
                        if (r_y != r_y1) begin
                            r_y    <= r_y + HW'(1);
                            r_base <= r_base + AW'(eff_w);
                        end
                    end else begin
                        r_x <= r_x + WW'(1);
                    end
                end else begin
                    r_pend <= 1'b0;
                    r_cnt  <= CNTW'(SW);
                    for (int i = 0; i < NUM_CHAN; i++)
                        r_mrem[i] <= '0;
                end
            end
            S_DIVM: begin
                r_cnt <= r_cnt - CNTW'(1);
                for (int i = 0; i < NUM_CHAN; i++) begin
                    r_sum[i]  <= {r_sum[i][SW-2:0], md_ge[i]};
                    r_mrem[i] <= md_ge[i] ? md_sub[i][NW-1:0] : md_sh[i][NW-1:0];
                end
            end
            S_OUT: begin
                if (out_free) begin
                    r_out_data <= res_pix;
                    r_out_last <= pos_last;
                end
            end
            default: ;
        endcase
    end

    // a load request goes straight to the store write
    a_load_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_LOAD) |=> r_state == S_LOAD)
        else $error("load request did not reach store write");

    // column from the position split is inside the row
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_BOUNDS |-> r_drem < eff_w)
        else $error("column out of range after split");

    a_scan_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> r_x <= r_x1 && r_y <= r_y1)
        else $error("scan left the window");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIVM |-> r_npix != '0 && r_cmd == CMD_REQUEST)
        else $error("mean division with empty window");

    // every mean fits one channel
    a_mean_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT |-> r_sum[0][SW-1:CHAN_W] == '0 && r_sum[1][SW-1:CHAN_W] == '0
                             && r_sum[2][SW-1:CHAN_W] == '0)
        else $error("channel mean overflow");

endmodule
